// ===== design/xy_route_link_load_counter_core_macros.svh =====
// Assertion macros shared by the link load counter RTL.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef XY_ROUTE_LINK_LOAD_COUNTER_CORE_MACROS_SVH
`define XY_ROUTE_LINK_LOAD_COUNTER_CORE_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked on every rising clock edge outside reset.
`define XYLC_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("xylc: implication check failed");
// Next-cycle implication, checked on every rising clock edge outside reset.
`define XYLC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("xylc: next-cycle check failed");
`else
`define XYLC_ASSERT_IMP(label, clk, rst, ante, cons)
`define XYLC_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== design/xylc_pkg.sv =====
// Types, codes and constants of the XY route link load counter.
// Depends on nothing; used by every module of the block but xylc_ram.
package xylc_pkg;

   localparam int MESH_X_DEF = 6;
   localparam int MESH_Y_DEF = 8;
   localparam int COORD_W    = 3;
   localparam int LOAD_W     = 32;
   localparam int HOPS_W     = 4;

   typedef enum logic [1:0] {
      CMD_CLEAR = 2'd0,
      CMD_ROUTE = 2'd1,
      CMD_READ  = 2'd2
   } cmd_type;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_CLEAR,
      ST_WALK,
      ST_RD_ADDR,
      ST_RD_DATA,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [1:0]         command;
      logic [COORD_W-1:0] src_x;
      logic [COORD_W-1:0] src_y;
      logic [COORD_W-1:0] dst_x;
      logic [COORD_W-1:0] dst_y;
      logic [LOAD_W-1:0]  weight;
      logic [COORD_W-1:0] read_x;
      logic [COORD_W-1:0] read_y;
   } req_type;

   typedef struct packed {
      logic [LOAD_W-1:0] x_load;
      logic [LOAD_W-1:0] y_load;
      logic [HOPS_W-1:0] hops;
      logic              saturated;
   } rsp_type;

   // Result of one pass through the shared saturating adder.
   typedef struct packed {
      logic [LOAD_W-1:0] sum;
      logic              saturated;
   } add_res_type;

endpackage

// ===== design/xylc_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module xylc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 48
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/xylc_sat_add.sv =====
// Shared saturating adder used for every link counter update.
// Depends on xylc_pkg.
module xylc_sat_add (
   input  logic [xylc_pkg::LOAD_W-1:0] old_load,
   input  logic [xylc_pkg::LOAD_W-1:0] weight,
   output xylc_pkg::add_res_type       result
);
   import xylc_pkg::*;

   logic [LOAD_W:0] wide_sum;

   assign wide_sum = {1'b0, old_load} + {1'b0, weight};

   // A carry out of the top bit means the counter would pass its maximum.
   always_comb begin
      result.saturated = wide_sum[LOAD_W];
      result.sum       = wide_sum[LOAD_W] ? {LOAD_W{1'b1}} : wide_sum[LOAD_W-1:0];
   end

endmodule

// ===== design/xy_route_link_load_counter_core.sv =====
// Top level of the XY route link load counter: sequencer, path walker and stores.
// Depends on xylc_pkg, xylc_ram, xylc_sat_add and the assertion macro header.
//
//   Channel | Direction | Handshake            | Payload
//   req     | in        | req_valid/req_ready  | req_data (xylc_pkg::req_type)
//   rsp     | out       | rsp_valid/rsp_ready  | rsp_data (xylc_pkg::rsp_type)
//
// A route does one link read-modify-write per hop through the shared saturating
// adder, with the read of the next link overlapping the write of the last.
// Clear, and also reset, sweeps all MESH_X * MESH_Y entries of both link RAMs one
// entry per cycle; req_ready stays low during the sweep.
// The result sits in an output register, so one finished result may wait on a stalled
// rsp channel while the next item is taken; a second result waits in the done state.
`include "xy_route_link_load_counter_core_macros.svh"

module xy_route_link_load_counter_core #(
   parameter int MESH_X = xylc_pkg::MESH_X_DEF,
   parameter int MESH_Y = xylc_pkg::MESH_Y_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  xylc_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output xylc_pkg::rsp_type rsp_data
);
   import xylc_pkg::*;

   localparam int NODES  = MESH_X * MESH_Y;
   localparam int NODE_W = $clog2(NODES);

   // Node index of column x, row y in row-major order.
   function automatic logic [NODE_W-1:0] node_at(input logic [COORD_W-1:0] x,
                                                 input logic [COORD_W-1:0] y);
      logic [31:0] idx;
      idx = 32'(y) * 32'(MESH_X) + 32'(x);
      return idx[NODE_W-1:0];
   endfunction

   state_type          state_ff, state_in;
   req_type            item_ff;
   logic [COORD_W-1:0] x_ff, x_in, y_ff, y_in;
   logic [HOPS_W-1:0]  hops_ff, hops_in;
   logic               sat_ff, sat_in;
   logic [LOAD_W-1:0]  xl_ff, xl_in, yl_ff, yl_in;
   logic               pend_ff, pend_in;
   logic               pend_north_ff, pend_north_in;
   logic [NODE_W-1:0]  pend_addr_ff, pend_addr_in;
   logic [NODE_W-1:0]  cnt_ff, cnt_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff, rsp_data_in;

   // Walker: the next link crossed from the current position.
   logic               move_x, move_y, hop_valid, hop_north;
   logic [COORD_W-1:0] hop_x, hop_y, next_x, next_y;
   logic [NODE_W-1:0]  hop_addr;
   logic               route_ok, read_ok, sweep_last;

   // Store ports.
   logic               east_we, north_we;
   logic [NODE_W-1:0]  wr_addr, rd_addr;
   logic [LOAD_W-1:0]  wr_data, east_rd, north_rd, old_load;
   add_res_type        add_res;

   xylc_ram #(.WIDTH(LOAD_W), .DEPTH(NODES)) u_east_ram (
      .clock   (clock),
      .wr_en   (east_we),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (east_rd)
   );

   xylc_ram #(.WIDTH(LOAD_W), .DEPTH(NODES)) u_north_ram (
      .clock   (clock),
      .wr_en   (north_we),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (north_rd)
   );

   assign old_load = pend_north_ff ? north_rd : east_rd;

   xylc_sat_add u_sat_add (
      .old_load (old_load),
      .weight   (item_ff.weight),
      .result   (add_res)
   );

   // XY order: all X hops first, then Y hops in the destination column. Link i of a
   // row or column joins node i and node i+1, so a step down uses the lower node.
   always_comb begin
      move_x    = (x_ff != item_ff.dst_x);
      move_y    = (y_ff != item_ff.dst_y);
      hop_valid = move_x || move_y;
      hop_north = !move_x;
      hop_x     = x_ff;
      hop_y     = y_ff;
      next_x    = x_ff;
      next_y    = y_ff;
      if (move_x) begin
         if (x_ff > item_ff.dst_x) begin
            hop_x  = x_ff - 1'b1;
            next_x = x_ff - 1'b1;
         end else begin
            next_x = x_ff + 1'b1;
         end
      end else if (move_y) begin
         if (y_ff > item_ff.dst_y) begin
            hop_y  = y_ff - 1'b1;
            next_y = y_ff - 1'b1;
         end else begin
            next_y = y_ff + 1'b1;
         end
      end
      hop_addr = node_at(hop_x, hop_y);
   end

   assign route_ok = (32'(req_data.src_x) < 32'(MESH_X)) && (32'(req_data.dst_x) < 32'(MESH_X))
                  && (32'(req_data.src_y) < 32'(MESH_Y)) && (32'(req_data.dst_y) < 32'(MESH_Y));
   assign read_ok  = (32'(item_ff.read_x) < 32'(MESH_X)) && (32'(item_ff.read_y) < 32'(MESH_Y));
   assign sweep_last = (cnt_ff == NODE_W'(NODES - 1));

   assign rd_addr   = (state_ff == ST_RD_ADDR) ? node_at(item_ff.read_x, item_ff.read_y)
                                               : hop_addr;
   assign req_ready = (state_ff == ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         cnt_ff       <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_ff <= req_data;
      end
      x_ff          <= x_in;
      y_ff          <= y_in;
      hops_ff       <= hops_in;
      sat_ff        <= sat_in;
      xl_ff         <= xl_in;
      yl_ff         <= yl_in;
      pend_north_ff <= pend_north_in;
      pend_addr_ff  <= pend_addr_in;
      rsp_data_ff   <= rsp_data_in;
   end

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      x_in          = x_ff;
      y_in          = y_ff;
      hops_in       = hops_ff;
      sat_in        = sat_ff;
      xl_in         = xl_ff;
      yl_in         = yl_ff;
      pend_in       = 1'b0;
      pend_north_in = pend_north_ff;
      pend_addr_in  = pend_addr_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_data_in   = rsp_data_ff;
      east_we       = 1'b0;
      north_we      = 1'b0;
      wr_addr       = pend_addr_ff;
      wr_data       = add_res.sum;

      case (state_ff)
         ST_INIT, ST_CLEAR: begin
            east_we  = 1'b1;
            north_we = 1'b1;
            wr_addr  = cnt_ff;
            wr_data  = '0;
            cnt_in   = cnt_ff + 1'b1;
            if (sweep_last) begin
               cnt_in   = '0;
               state_in = (state_ff == ST_INIT) ? ST_IDLE : ST_DONE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               xl_in   = '0;
               yl_in   = '0;
               hops_in = '0;
               sat_in  = 1'b0;
               cnt_in  = '0;
               case (req_data.command)
                  CMD_CLEAR: state_in = ST_CLEAR;
                  CMD_ROUTE: begin
                     x_in     = req_data.src_x;
                     y_in     = req_data.src_y;
                     state_in = route_ok ? ST_WALK : ST_DONE;
                  end
                  CMD_READ: state_in = ST_RD_ADDR;
                  default:  state_in = ST_DONE;
               endcase
            end
         end
         ST_WALK: begin
            // Write back the link read last cycle while the next link is read.
            if (pend_ff) begin
               east_we  = !pend_north_ff;
               north_we = pend_north_ff;
               sat_in   = sat_ff | add_res.saturated;
            end
            if (hop_valid) begin
               pend_in       = 1'b1;
               pend_north_in = hop_north;
               pend_addr_in  = hop_addr;
               hops_in       = hops_ff + 1'b1;
               x_in          = next_x;
               y_in          = next_y;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_RD_ADDR: state_in = ST_RD_DATA;
         ST_RD_DATA: begin
            if (read_ok) begin
               xl_in = east_rd;
               yl_in = north_rd;
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in          = 1'b1;
               rsp_data_in.x_load    = xl_ff;
               rsp_data_in.y_load    = yl_ff;
               rsp_data_in.hops      = hops_ff;
               rsp_data_in.saturated = sat_ff;
               state_in              = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // A write-back never lands on the link being read in the same cycle.
   `XYLC_ASSERT_IMP(a_no_rmw_overlap, clock, reset,
      (state_ff == ST_WALK) && pend_ff && hop_valid && (hop_north == pend_north_ff),
      hop_addr != pend_addr_ff)
   // A pending write-back only exists while a route is being walked.
   `XYLC_ASSERT_IMP(a_pend_in_walk, clock, reset, pend_ff, state_ff == ST_WALK)
   // The sweep address stays inside the stores.
   `XYLC_ASSERT_IMP(a_sweep_range, clock, reset,
      (state_ff == ST_INIT) || (state_ff == ST_CLEAR), cnt_ff <= NODE_W'(NODES - 1))
   // Saturation can only be reported by a route that crossed at least one link.
   `XYLC_ASSERT_IMP(a_sat_has_hops, clock, reset,
      (state_ff == ST_DONE) && sat_ff, hops_ff != '0)
   // Once the walker runs out of hops, the next cycle delivers or holds the result.
   `XYLC_ASSERT_NEXT(a_walk_ends, clock, reset,
      (state_ff == ST_WALK) && !hop_valid, state_ff == ST_DONE)

endmodule

// ===== tb/sv/xylc_link_load_sb_pkg.sv =====
`timescale 1ns / 100ps
// Scoreboard for the XY route link load counter: a untimed model of both link load
// stores and the queue of results it predicts. Depends on xylc_pkg.
package xylc_link_load_sb_pkg;
   import xylc_pkg::*;

   localparam int NODE_COUNT = MESH_X_DEF * MESH_Y_DEF;
   localparam int NODE_W     = $clog2(NODE_COUNT);

   // Row-major index of the node at column x, row y.
   function automatic logic [NODE_W-1:0] node_index(int x, int y);
      return NODE_W'(y * MESH_X_DEF + x);
   endfunction

   class link_load_scoreboard;
      logic [LOAD_W-1:0] east_load  [NODE_COUNT];
      logic [LOAD_W-1:0] north_load [NODE_COUNT];
      rsp_type           outstanding_rsp [$];
      int                failures;

      function new();
         clear_loads();
         failures = 0;
      endfunction

      function void clear_loads();
         foreach (east_load[i]) begin
            east_load[i]  = '0;
            north_load[i] = '0;
         end
      endfunction

      // Saturating add of one hop's weight into one link counter.
      function void add_to_link(inout logic [LOAD_W-1:0] link_count,
                                input logic [LOAD_W-1:0] weight,
                                inout logic              sat_flag);
         logic [LOAD_W:0] sum;
         sum = {1'b0, link_count} + {1'b0, weight};
         if (sum[LOAD_W]) begin
            link_count = '1;
            sat_flag   = 1'b1;
         end else begin
            link_count = sum[LOAD_W-1:0];
         end
      endfunction

      function rsp_type walk_route_or_read(req_type item);
         rsp_type res;
         int      x;
         int      y;
         int      dx;
         int      dy;
         res = '0;
         dx  = int'(item.dst_x);
         dy  = int'(item.dst_y);
         case (item.command)
            CMD_CLEAR: begin
               clear_loads();
            end
            CMD_ROUTE: begin
               if (int'(item.src_x) < MESH_X_DEF && dx < MESH_X_DEF &&
                   int'(item.src_y) < MESH_Y_DEF && dy < MESH_Y_DEF) begin
                  x = int'(item.src_x);
                  y = int'(item.src_y);
                  // X first along the source row, then Y in the destination column.
                  while (x != dx) begin
                     if (x > dx) begin
                        add_to_link(east_load[node_index(x - 1, y)], item.weight,
                                    res.saturated);
                        x--;
                     end else begin
                        add_to_link(east_load[node_index(x, y)], item.weight,
                                    res.saturated);
                        x++;
                     end
                     res.hops = res.hops + 1'b1;
                  end
                  while (y != dy) begin
                     if (y > dy) begin
                        add_to_link(north_load[node_index(x, y - 1)], item.weight,
                                    res.saturated);
                        y--;
                     end else begin
                        add_to_link(north_load[node_index(x, y)], item.weight,
                                    res.saturated);
                        y++;
                     end
                     res.hops = res.hops + 1'b1;
                  end
               end
            end
            CMD_READ: begin
               if (int'(item.read_x) < MESH_X_DEF && int'(item.read_y) < MESH_Y_DEF) begin
                  res.x_load = east_load[node_index(int'(item.read_x), int'(item.read_y))];
                  res.y_load = north_load[node_index(int'(item.read_x), int'(item.read_y))];
               end
            end
            default: begin
            end
         endcase
         return res;
      endfunction

      function void note_request(req_type item);
         outstanding_rsp.push_back(walk_route_or_read(item));
      endfunction

      function int outstanding();
         return outstanding_rsp.size();
      endfunction

      function void check_response(rsp_type got);
         rsp_type want;
         if (outstanding_rsp.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %p", $time, got);
            failures++;
            return;
         end
         want = outstanding_rsp.pop_front();
         if (got.x_load !== want.x_load) begin
            $display("%0t: x_load mismatch, expected %h, actual %h",
                     $time, want.x_load, got.x_load);
            failures++;
         end
         if (got.y_load !== want.y_load) begin
            $display("%0t: y_load mismatch, expected %h, actual %h",
                     $time, want.y_load, got.y_load);
            failures++;
         end
         if (got.hops !== want.hops) begin
            $display("%0t: hops mismatch, expected %0d, actual %0d",
                     $time, want.hops, got.hops);
            failures++;
         end
         if (got.saturated !== want.saturated) begin
            $display("%0t: saturated mismatch, expected %b, actual %b",
                     $time, want.saturated, got.saturated);
            failures++;
         end
      endfunction
   endclass

endpackage

// ===== tb/sv/xy_route_link_load_counter_core_tb.sv =====
`timescale 1ns / 100ps
// Testbench top for the XY route link load counter core: drives directed and random
// commands, stalls both channels and checks every result. Depends on xylc_pkg and
// xylc_link_load_sb_pkg.
module xy_route_link_load_counter_core_tb;
   import xylc_pkg::*;
   import xylc_link_load_sb_pkg::*;

   localparam int         CLK_PERIOD     = 10;
   localparam int         RESET_CYCLES   = 6;
   localparam int         RANDOM_ITEMS   = 1800;
   localparam int         MAX_GAP        = 13;
   // Long receiver hold that lets the output register and done state fill up.
   localparam int         HOLD_CYCLES    = 300;
   // Nothing may sit idle longer than this; the slowest legal stretch is the hold
   // above plus a clear sweep and the longest gaps, well under this figure.
   localparam int         WATCHDOG_LIMIT = 4000;
   // Time spent watching for stray results once no result is outstanding.
   localparam int         DRAIN_CYCLES   = 40;
   localparam logic [1:0] CMD_UNUSED     = 2'd3;

   logic    clock = 1'b0;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   link_load_scoreboard sb;
   int                  sent_count  = 0;
   int                  idle_cycles = 0;
   bit                  send_calm   = 1'b0;

   always #(CLK_PERIOD / 2) clock = ~clock;

   xy_route_link_load_counter_core DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // Watchdog: any cycle without a transfer on either channel counts toward the
   // limit. All signals are sampled at the edge, before this step's updates land.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Verification failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic req_type make_request(logic [1:0] command,
                                            int sx, int sy, int dx, int dy,
                                            logic [LOAD_W-1:0] weight,
                                            int rx, int ry);
      req_type item;
      item.command = command;
      item.src_x   = COORD_W'(sx);
      item.src_y   = COORD_W'(sy);
      item.dst_x   = COORD_W'(dx);
      item.dst_y   = COORD_W'(dy);
      item.weight  = weight;
      item.read_x  = COORD_W'(rx);
      item.read_y  = COORD_W'(ry);
      return item;
   endfunction

   // Columns 6 and 7 exist in the field but not on the mesh; hit them now and then.
   function automatic logic [COORD_W-1:0] random_column();
      if ($urandom_range(0, 9) == 0) begin
         return COORD_W'($urandom_range(MESH_X_DEF, 7));
      end
      return COORD_W'($urandom_range(0, MESH_X_DEF - 1));
   endfunction

   // Weights mix small values, full random words, values just under the maximum,
   // single bits and zero, so counters both sum exactly and saturate.
   function automatic logic [LOAD_W-1:0] random_weight();
      int kind;
      kind = $urandom_range(0, 9);
      if (kind <= 4) begin
         return $urandom_range(0, 255);
      end else if (kind <= 6) begin
         return $urandom;
      end else if (kind == 7) begin
         return 32'hFFFF_FFFF - $urandom_range(0, 15);
      end else if (kind == 8) begin
         return 32'd1 << $urandom_range(0, 31);
      end
      return '0;
   endfunction

   // Builds one random command. Unused command codes and routes with an endpoint off
   // the mesh are flagged as ignored so they do not count toward the item total.
   function automatic req_type random_request(output bit ignored);
      req_type item;
      int      pick;
      item.src_x  = random_column();
      item.src_y  = COORD_W'($urandom_range(0, 7));
      item.dst_x  = random_column();
      item.dst_y  = COORD_W'($urandom_range(0, 7));
      item.weight = random_weight();
      item.read_x = random_column();
      item.read_y = COORD_W'($urandom_range(0, 7));
      pick = $urandom_range(0, 99);
      if (pick < 46) begin
         item.command = CMD_ROUTE;
      end else if (pick < 91) begin
         item.command = CMD_READ;
      end else if (pick < 94) begin
         item.command = CMD_CLEAR;
      end else begin
         item.command = CMD_UNUSED;
      end
      ignored = (item.command == CMD_UNUSED) ||
                (item.command == CMD_ROUTE &&
                 (int'(item.src_x) >= MESH_X_DEF || int'(item.dst_x) >= MESH_X_DEF));
      return item;
   endfunction

   // Offers one item after a random gap and returns at the edge where the transfer
   // happens. When the next item follows with no gap, valid simply stays high, so
   // valid gets only one assignment per time step.
   task automatic send_request(input req_type item);
      int gap;
      if (sent_count % 50 == 0) begin
         send_calm = ($urandom_range(0, 3) == 0);
      end
      gap = send_calm ? 0 : $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      sb.note_request(item);
      sent_count++;
   endtask

   // Result side. It stalls at random, runs without stalls for some stretches, and
   // twice holds ready low long enough for the block to back up into its input.
   task automatic receive_responses();
      int gap;
      int taken;
      bit calm;
      taken = 0;
      calm  = 1'b0;
      forever begin
         if (taken % 50 == 0) begin
            calm = ($urandom_range(0, 3) == 0);
         end
         if (taken == 200 || taken == 1000) begin
            gap = HOLD_CYCLES;
         end else begin
            gap = calm ? 0 : $urandom_range(0, MAX_GAP);
         end
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         sb.check_response(rsp_data);
         taken++;
      end
   endtask

   // Directed opening: the longest routes both ways, saturation and its edge cases,
   // routes to self, off-mesh routes and reads, the edge links, the unused command
   // and a clear in the middle.
   task automatic directed_requests();
      send_request(make_request(CMD_READ,  0, 0, 0, 0, 32'h0, 0, 0));
      send_request(make_request(CMD_ROUTE, 0, 0, 5, 7, 32'hFFFF_FFFF, 0, 0));
      // Every link on the path is now full, so a weight of one saturates them all.
      send_request(make_request(CMD_ROUTE, 0, 0, 5, 7, 32'h1, 7, 7));
      // A full counter with a zero weight must not raise the flag.
      send_request(make_request(CMD_ROUTE, 0, 0, 5, 7, 32'h0, 0, 0));
      send_request(make_request(CMD_READ,  0, 0, 0, 0, 32'h0, 0, 0));
      send_request(make_request(CMD_READ,  0, 0, 0, 0, 32'h0, 5, 0));
      send_request(make_request(CMD_READ,  0, 0, 0, 0, 32'h0, 5, 6));
      // Top-right corner: its east and north links are never crossed.
      send_request(make_request(CMD_READ,  0, 0, 0, 0, 32'h0, 5, 7));
      // West along the top row, then south down column zero.
      send_request(make_request(CMD_ROUTE, 5, 7, 0, 0, 32'h5A5A_5A5A, 0, 0));
      send_request(make_request(CMD_READ,  7, 7, 7, 7, 32'hFFFF_FFFF, 2, 7));
      send_request(make_request(CMD_READ,  0, 0, 0, 0, 32'h0, 0, 3));
      send_request(make_request(CMD_ROUTE, 3, 4, 3, 4, 32'h7, 0, 0));
      send_request(make_request(CMD_ROUTE, 6, 2, 1, 2, 32'h10, 0, 0));
      send_request(make_request(CMD_ROUTE, 1, 2, 7, 5, 32'h10, 0, 0));
      send_request(make_request(CMD_READ,  0, 0, 0, 0, 32'h0, 7, 7));
      send_request(make_request(CMD_READ,  0, 0, 0, 0, 32'h0, 6, 0));
      send_request(make_request(CMD_UNUSED, 7, 7, 7, 7, 32'hFFFF_FFFF, 7, 7));
      send_request(make_request(CMD_CLEAR, 7, 7, 7, 7, 32'hFFFF_FFFF, 7, 7));
      send_request(make_request(CMD_READ,  0, 0, 0, 0, 32'h0, 5, 0));
      send_request(make_request(CMD_ROUTE, 4, 6, 1, 6, 32'hA5A5_A5A5, 0, 0));
      send_request(make_request(CMD_READ,  0, 0, 0, 0, 32'h0, 1, 6));
      // North then back south over the same column links; the second run saturates.
      send_request(make_request(CMD_ROUTE, 1, 1, 1, 6, 32'hFFFF_FFFE, 0, 0));
      send_request(make_request(CMD_ROUTE, 1, 6, 1, 1, 32'h3, 0, 0));
      send_request(make_request(CMD_READ,  0, 0, 0, 0, 32'h0, 1, 3));
   endtask

   initial begin
      req_type item;
      bit      ignored;
      int      useful;
      sb = new();
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      rsp_ready <= 1'b0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // The block sweeps its link RAMs after reset with req_ready low; the first
      // transfer simply waits for it.
      fork
         receive_responses();
      join_none

      directed_requests();

      useful = 0;
      while (useful < RANDOM_ITEMS) begin
         item = random_request(ignored);
         send_request(item);
         if (!ignored) begin
            useful++;
         end
      end
      req_valid <= 1'b0;

      // Let every outstanding result arrive, then watch a while for strays.
      while (sb.outstanding() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (sb.failures == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
